// ===== rtl/bfu_pkg.sv =====
// Shared widths, codes, reset values and the channel blend function of the frame upscaler.
`timescale 1ns / 1ps

package bfu_pkg;

   localparam int DIM_W       = 13;
   localparam int INDEX_W     = 17;
   localparam int PIXEL_W     = 32;
   localparam int CSR_INDEX_W = 2;

   localparam int DEF_SRC_WIDTH  = 320;
   localparam int DEF_SRC_HEIGHT = 240;
   localparam int DEF_MAX_DIM    = 4096;

   localparam logic [DIM_W-1:0] RESET_OUT_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RESET_OUT_HEIGHT = 13'd480;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_HEIGHT = 2'd1;

   typedef logic [PIXEL_W-1:0] pixel_type;

   localparam pixel_type ALPHA_OPAQUE = 32'hFF00_0000;

   // Blends the three colour channels with truncation; the alpha byte of the result is zero.
   function automatic pixel_type blend8(pixel_type a, pixel_type b, logic [7:0] f);
      logic [8:0]  g;
      logic [16:0] pa;
      logic [16:0] pb;
      logic [16:0] acc;
      pixel_type   res;
      g   = 9'd256 - {1'b0, f};
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         pa  = {9'd0, a[8*ch +: 8]} * {8'd0, g};
         pb  = {9'd0, b[8*ch +: 8]} * {9'd0, f};
         acc = pa + pb;
         res[8*ch +: 8] = acc[15:8];
      end
      return res;
   endfunction

endpackage

// ===== rtl/bilinear_frame_upscaler.sv =====
// Top level of the frame upscaler: configuration, sequencer, frame store and blending.
// A load transfer gives no result, and the next item is taken at once.
// A sample runs two serial divisions (one quotient bit per cycle, with a 38-bit numerator
// at a 320x240 source), four frame-store reads and three blend steps; a nearest-mode
// sample makes one read and no blend. Reset clears the sequencer and the result valid
// flag and sets the sizes to 640x480; the store and the result registers are not reset.
`timescale 1ns / 1ps

module bilinear_frame_upscaler #(
   parameter int SRC_WIDTH  = bfu_pkg::DEF_SRC_WIDTH,
   parameter int SRC_HEIGHT = bfu_pkg::DEF_SRC_HEIGHT,
   parameter int MAX_DIM    = bfu_pkg::DEF_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [bfu_pkg::INDEX_W-1:0]     req_src_index,
   input  logic [bfu_pkg::PIXEL_W-1:0]     req_src_pixel,
   input  logic [bfu_pkg::DIM_W-1:0]       req_out_x,
   input  logic [bfu_pkg::DIM_W-1:0]       req_out_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bfu_pkg::PIXEL_W-1:0]     rsp_out_pixel,
   input  logic                            csr_write,
   input  logic [bfu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfu_pkg::DIM_W-1:0]       csr_wdata
);

   localparam int DEPTH   = SRC_WIDTH * SRC_HEIGHT;
   localparam int AW      = $clog2(DEPTH);
   localparam int XW      = $clog2(SRC_WIDTH);
   localparam int YW      = $clog2(SRC_HEIGHT);
   localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
   localparam int SW      = $clog2(SRC_MAX + 1);
   localparam int PW      = bfu_pkg::DIM_W + 1 + SW;
   localparam int NUM_W   = PW + 15;

   localparam logic [NUM_W-1:0] HALF  = NUM_W'(32768);
   localparam logic [NUM_W-1:0] X_M1  = NUM_W'(SRC_WIDTH - 1);
   localparam logic [NUM_W-1:0] Y_M1  = NUM_W'(SRC_HEIGHT - 1);
   localparam logic [NUM_W-1:0] X_LIM = X_M1 << 16;
   localparam logic [NUM_W-1:0] Y_LIM = Y_M1 << 16;

   localparam logic AXIS_Y = 1'b0;
   localparam logic AXIS_X = 1'b1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_POS   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_LERP  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [2:0] RD_LAST = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic                          axis_ff, axis_in;
   logic                          near_ff, near_in;
   logic [bfu_pkg::DIM_W-1:0]     x_ff, x_in;
   logic [bfu_pkg::DIM_W-1:0]     y_ff, y_in;
   logic [PW-1:0]                 prod_ff, prod_in;
   logic [YW-1:0]                 y0_ff, y0_in, y1_ff, y1_in;
   logic [XW-1:0]                 x0_ff, x0_in, x1_ff, x1_in;
   logic [7:0]                    fy_ff, fy_in, fx_ff, fx_in;
   logic [AW-1:0]                 base0_ff, base0_in, base1_ff, base1_in;
   logic [2:0]                    rd_cnt_ff, rd_cnt_in;
   logic [1:0]                    step_ff, step_in;
   bfu_pkg::pixel_type            p00_ff, p00_in, p10_ff, p10_in;
   bfu_pkg::pixel_type            p01_ff, p01_in, p11_ff, p11_in;
   bfu_pkg::pixel_type            res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bfu_pkg::pixel_type            rsp_pixel_ff, rsp_pixel_in;
   logic [bfu_pkg::DIM_W-1:0]     out_width_ff, out_width_in;
   logic [bfu_pkg::DIM_W-1:0]     out_height_ff, out_height_in;

   logic                          req_accept;
   logic                          out_free;
   logic [bfu_pkg::DIM_W-1:0]     w_eff, h_eff;
   logic                          near_mode;
   logic [bfu_pkg::DIM_W-1:0]     coord;
   logic [bfu_pkg::DIM_W:0]       term;
   logic [SW-1:0]                 src_sel;
   logic                          div_start, div_done;
   logic [NUM_W-1:0]              div_numer, div_quot;
   logic [bfu_pkg::DIM_W-1:0]     div_denom;
   logic [NUM_W-1:0]              srcm1, lim, qs, pos, near_idx, c_full, c_next;
   logic [7:0]                    frac;
   logic                          ram_wr_en, ram_rd_en;
   logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
   bfu_pkg::pixel_type            ram_rd_data;
   bfu_pkg::pixel_type            lerp_a, lerp_b, lerp_out;
   logic [7:0]                    lerp_f;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != S_IDLE;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign w_eff     = (out_width_ff == '0) ? bfu_pkg::DIM_W'(1) : out_width_ff;
   assign h_eff     = (out_height_ff == '0) ? bfu_pkg::DIM_W'(1) : out_height_ff;
   assign near_mode = (w_eff > bfu_pkg::DIM_W'(MAX_DIM)) || (h_eff > bfu_pkg::DIM_W'(MAX_DIM));

   always_comb begin
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (csr_write && csr_index == bfu_pkg::CSR_OUT_WIDTH) begin
         out_width_in = csr_wdata;
      end
      if (csr_write && csr_index == bfu_pkg::CSR_OUT_HEIGHT) begin
         out_height_in = csr_wdata;
      end
   end

   assign ram_wr_en   = req_accept && req_action == bfu_pkg::ACTION_LOAD
                        && ({15'd0, req_src_index} < 32'(DEPTH));
   assign ram_wr_addr = AW'(req_src_index);

   bfu_ram #(
      .WIDTH (bfu_pkg::PIXEL_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_src_pixel),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign coord   = (axis_ff == AXIS_X) ? x_ff : y_ff;
   assign term    = near_ff ? {1'b0, coord} : {coord, 1'b1};
   assign src_sel = (axis_ff == AXIS_X) ? SW'(SRC_WIDTH) : SW'(SRC_HEIGHT);

   assign div_numer = near_ff ? NUM_W'(prod_ff) : {prod_ff, 15'd0};
   assign div_denom = (axis_ff == AXIS_X) ? w_eff : h_eff;

   bfu_div #(
      .NUM_W (NUM_W),
      .DEN_W (bfu_pkg::DIM_W)
   ) u_bfu_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign srcm1    = (axis_ff == AXIS_X) ? X_M1 : Y_M1;
   assign lim      = (axis_ff == AXIS_X) ? X_LIM : Y_LIM;
   assign qs       = (div_quot < HALF) ? '0 : div_quot - HALF;
   assign pos      = (qs > lim) ? lim : qs;
   assign near_idx = (div_quot > srcm1) ? srcm1 : div_quot;
   assign c_full   = near_ff ? near_idx : (pos >> 16);
   assign c_next   = (c_full < srcm1) ? c_full + NUM_W'(1) : c_full;
   assign frac     = near_ff ? 8'd0 : pos[15:8];

   assign ram_rd_addr = (rd_cnt_ff[0] ? base1_ff : base0_ff)
                        + AW'(rd_cnt_ff[1] ? x1_ff : x0_ff);

   always_comb begin
      unique case (step_ff)
         2'd0: begin
            lerp_a = p00_ff;
            lerp_b = p10_ff;
            lerp_f = fy_ff;
         end
         2'd1: begin
            lerp_a = p01_ff;
            lerp_b = p11_ff;
            lerp_f = fy_ff;
         end
         default: begin
            lerp_a = p00_ff;
            lerp_b = p10_ff;
            lerp_f = fx_ff;
         end
      endcase
   end

   assign lerp_out = bfu_pkg::blend8(lerp_a, lerp_b, lerp_f);

   assign base0_in = AW'(y0_ff * SRC_WIDTH);
   assign base1_in = AW'(y1_ff * SRC_WIDTH);

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      near_in   = near_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      prod_in   = prod_ff;
      y0_in     = y0_ff;
      y1_in     = y1_ff;
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      fy_in     = fy_ff;
      fx_in     = fx_ff;
      rd_cnt_in = rd_cnt_ff;
      step_in   = step_ff;
      p00_in    = p00_ff;
      p10_in    = p10_ff;
      p01_in    = p01_ff;
      p11_in    = p11_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_action == bfu_pkg::ACTION_SAMPLE) begin
               x_in     = req_out_x;
               y_in     = req_out_y;
               near_in  = near_mode;
               axis_in  = AXIS_Y;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PW'(term) * PW'(src_sel);
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               state_in = S_POS;
            end
         end
         S_POS: begin
            if (axis_ff == AXIS_Y) begin
               y0_in    = c_full[YW-1:0];
               y1_in    = c_next[YW-1:0];
               fy_in    = frac;
               axis_in  = AXIS_X;
               state_in = S_MUL;
            end else begin
               x0_in     = c_full[XW-1:0];
               x1_in     = c_next[XW-1:0];
               fx_in     = frac;
               rd_cnt_in = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            ram_rd_en = rd_cnt_ff < RD_LAST;
            unique case (rd_cnt_ff)
               3'd1:    p00_in = ram_rd_data;
               3'd2:    p10_in = ram_rd_data;
               3'd3:    p01_in = ram_rd_data;
               3'd4:    p11_in = ram_rd_data;
               default: p00_in = p00_ff;
            endcase
            if (near_ff && rd_cnt_ff == 3'd1) begin
               res_in   = ram_rd_data;
               state_in = S_DONE;
            end else if (rd_cnt_ff == RD_LAST) begin
               step_in  = '0;
               state_in = S_LERP;
            end
         end
         S_LERP: begin
            step_in = step_ff + 2'd1;
            unique case (step_ff)
               2'd0:    p00_in = lerp_out;
               2'd1:    p10_in = lerp_out;
               default: begin
                  res_in   = bfu_pkg::ALPHA_OPAQUE | lerp_out;
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (state_ff == S_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         out_width_ff  <= bfu_pkg::RESET_OUT_WIDTH;
         out_height_ff <= bfu_pkg::RESET_OUT_HEIGHT;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
      end
      axis_ff      <= axis_in;
      near_ff      <= near_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      fy_ff        <= fy_in;
      fx_ff        <= fx_in;
      base0_ff     <= base0_in;
      base1_ff     <= base1_in;
      rd_cnt_ff    <= rd_cnt_in;
      step_ff      <= step_in;
      p00_ff       <= p00_in;
      p10_ff       <= p10_in;
      p01_ff       <= p01_in;
      p11_ff       <= p11_in;
      res_ff       <= res_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;

endmodule

// ===== rtl/bfu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module bfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfu_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module bfu_div #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] denom_ff, denom_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, quot_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, denom_ff};
   assign diff    = shifted - {1'b0, denom_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(NUM_W);
         rem_in   = '0;
         quot_in  = numer;
         denom_in = denom;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/bfu_checker.sv =====
// Port-level checker for the frame upscaler and the bind that attaches it.
`timescale 1ns / 1ps

module bfu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_action,
   input logic [bfu_pkg::INDEX_W-1:0]     req_src_index,
   input logic [bfu_pkg::PIXEL_W-1:0]     req_src_pixel,
   input logic [bfu_pkg::DIM_W-1:0]       req_out_x,
   input logic [bfu_pkg::DIM_W-1:0]       req_out_y,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bfu_pkg::PIXEL_W-1:0]     rsp_out_pixel,
   input logic                            csr_write,
   input logic [bfu_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [bfu_pkg::DIM_W-1:0]       csr_wdata
);

   // A load transfer never leaves the input channel stalled behind it.
   a_load_single_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == bfu_pkg::ACTION_LOAD |=> !req_stall)
      else $error("load transfer stalled the input channel");

   // A sample transfer occupies the block in the following cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == bfu_pkg::ACTION_SAMPLE |=> req_stall)
      else $error("input channel free straight after a sample transfer");

   // A result only appears at the end of sample work, never from an idle block.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while the block was idle");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("stalled result changed or was dropped");

endmodule

bind bilinear_frame_upscaler bfu_checker u_bfu_checker (.*);
